// File: sv/mjd_to_calendar_date_core_defines.svh
// Assertion macros shared by the calendar converter RTL.
`ifndef MJD_TO_CALENDAR_DATE_CORE_DEFINES_SVH
`define MJD_TO_CALENDAR_DATE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define MJDCAL_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mjdcal: implication check failed");

// Implication with a fixed delay in clock cycles.
`define MJDCAL_ASSERT_AFTER(name, ante, cycles, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##cycles (cons)) \
    else $error("mjdcal: latency check failed");

`endif

// File: sv/mjdcal_pkg.sv
// Types, constants and constant functions of the MJD to calendar converter.
`timescale 1ns / 1ps

package mjdcal_pkg;

  localparam int FRACTION_BITS = 32;

  typedef struct packed {
    logic signed [22:0]       mjd_day;
    logic [FRACTION_BITS-1:0] day_fraction;
  } in_item_t;

  typedef struct packed {
    logic [13:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [25:0] second_micro;
  } out_item_t;

  // First Gregorian day (JD 2299161) expressed as an MJD day.
  localparam logic signed [22:0] GREG_MJD   = -23'sd100840;
  localparam logic [23:0]        JD_OFFSET  = 24'd2400001;
  // 4*JD - 7468865 written directly in terms of the MJD day.
  localparam logic [24:0]        B_NUM_BIAS = 25'(4 * 2400001 - 7468865);

  localparam int          B_SHIFT  = 25;
  localparam logic [17:0] B_DIV    = 18'd146097;
  localparam logic [7:0]  B_RECIP  = 8'((64'd1 << B_SHIFT) / 64'd146097);

  localparam logic [10:0] C_GREG_OFS = 11'd1525;
  localparam logic [10:0] C_JUL_OFS  = 11'd1524;

  localparam int          D_SHIFT   = 30;
  localparam logic [15:0] D_DIV     = 16'd36525;
  localparam logic [12:0] D_BIAS    = 13'd5000;
  localparam logic [29:0] D_NUM_OFS = 30'(5000 * 36525 - 12210);
  localparam logic [14:0] D_RECIP   = 15'((64'd1 << D_SHIFT) / 64'd36525);

  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [13:0] YEAR_OFS   = 14'd4715;
  localparam logic [4:0]  F_YEAR_WRAP = 5'd14;
  localparam logic [5:0]  F_WRAP_SUB  = 6'd13;
  localparam logic [5:0]  MONTH_MARCH = 6'd3;
  localparam int          NUM_F_THRESH = 16;

  // Bounds of the day count g within the shifted year, mathematically bounded.
  localparam logic [8:0]  G_MIN = 9'd123;
  localparam logic [8:0]  G_MAX = 9'd488;

  localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
  localparam logic [10:0] MIN_PER_DAY    = 11'd1440;
  localparam logic [10:0] MIN_PER_HOUR   = 11'd60;
  // 86400000000 microseconds per day equals 10546875 shifted left by 13.
  localparam logic [23:0] US_DAY_ODD     = 24'd10546875;
  localparam int          US_DAY_SHIFT   = 13;
  localparam logic [25:0] US_PER_MIN     = 26'd60000000;
  localparam logic [25:0] US_PER_MIN_MAX = 26'd59999999;

  // Smallest day count g for which floor(10000*g/306001) reaches k.
  function automatic logic [8:0] month_threshold(int unsigned k);
    return 9'((306001 * k + 9999) / 10000);
  endfunction

  // floor(306001*k/10000): day count at the start of shifted month k.
  function automatic logic [8:0] month_offset(int unsigned k);
    return 9'((306001 * k) / 10000);
  endfunction

endpackage

// File: sv/mjd_to_calendar_date_core.sv
// Pipelined Modified Julian Date to calendar date and time of day converter.
`timescale 1ns / 1ps
`include "mjd_to_calendar_date_core_defines.svh"

// Usage
//   An item (signed MJD day plus a binary fraction of a day) is taken at every
//   rising edge where start is high and busy is low. busy is low whenever the
//   block is out of reset, so a new item can be presented in every cycle.
//   Each item yields exactly one result on out_result, marked by a one-cycle
//   out_valid strobe once the item has passed all ten register stages;
//   results leave in the order the items came in.
//   Throughput is one item per clock. Two reciprocal multiplies with a
//   correction step (for the divisions by 146097 and by 36525) dominate the
//   date path and set the depth; the time of day path runs in parallel and
//   is delayed to match.
//   The receiver has no way to hold results off: every result is shown for
//   one cycle only and must be captured then.
//   Reset is synchronous and active low. It clears the valid bits of all
//   stages, so no result appears for items that were in flight, and busy is
//   high while reset is held. No other register is reset.
module mjd_to_calendar_date_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  mjdcal_pkg::in_item_t   in_item,
  output logic                   out_valid,
  output mjdcal_pkg::out_item_t  out_result
);

  localparam int FB         = mjdcal_pkg::FRACTION_BITS;
  localparam int NUM_STAGES = 10;
  // The time of day result is formed in stage 2 and has to reach stage 9.
  localparam int TOD_DEPTH  = NUM_STAGES - 2;
  localparam int HP_W       = FB + 5;
  localparam int MP_W       = FB + 11;
  localparam int UP_W       = FB + mjdcal_pkg::US_DAY_SHIFT;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] micro;
  } tod_t;

  logic                  in_accept;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;

  // Stage 1: Julian day number and the Gregorian decision.
  logic signed [23:0] s1_a_nxt, s1_a_r;
  logic               s1_greg_nxt, s1_greg_r;
  logic [24:0]        s1_nb_nxt, s1_nb_r;
  logic [HP_W-1:0]    t1_hprod_nxt, t1_hprod_r;
  logic [MP_W-1:0]    t1_mprod_nxt, t1_mprod_r;
  logic [UP_W-1:0]    t1_uprod_nxt, t1_uprod_r;

  // Stage 2: reciprocal product for the century count.
  logic [32:0]        s2_pb_nxt, s2_pb_r;
  logic signed [23:0] s2_a_r;
  logic               s2_greg_r;
  logic [24:0]        s2_nb_r;

  // Stage 3: century count b.
  logic [7:0]         s3_qb;
  logic [24:0]        s3_rb;
  logic [7:0]         s3_b_nxt, s3_b_r;
  logic signed [23:0] s3_a_r;
  logic               s3_greg_r;

  // Stage 4: shifted day number c.
  logic [23:0]        s4_c_nxt, s4_c_r;

  // Stage 5: biased numerator for the year count.
  logic [29:0]        s5_nd_nxt, s5_nd_r;
  logic [8:0]         s5_clo_r;

  // Stage 6: reciprocal product for the year count.
  logic [44:0]        s6_pd_nxt, s6_pd_r;
  logic [29:0]        s6_nd_r;
  logic [8:0]         s6_clo_r;

  // Stage 7: year count d.
  logic [14:0]        s7_qd;
  logic [29:0]        s7_rd;
  logic [14:0]        s7_qd_fix;
  logic [15:0]        s7_d_nxt, s7_d_r;
  logic [8:0]         s7_clo_r;

  // Stage 8: day within the shifted year g.
  logic [8:0]         s8_e_lo;
  logic [8:0]         s8_g_nxt, s8_g_r;
  logic [15:0]        s8_d_r;

  // Stage 9: shifted month f.
  logic [mjdcal_pkg::NUM_F_THRESH-1:0] s9_ge;
  logic [4:0]         s9_f_nxt, s9_f_r;
  logic [8:0]         s9_g_r;
  logic [15:0]        s9_d_r;

  // Stage 10: output register.
  logic [8:0]         ofs_tab [32];
  logic [5:0]         s10_f6;
  logic [5:0]         s10_mon6;
  logic               s10_adj;
  logic [8:0]         s10_day9;
  mjdcal_pkg::out_item_t out_nxt, out_r;

  // Time of day path.
  logic [4:0]         t2_hours;
  logic [10:0]        t2_mtot;
  logic [25:0]        t2_ut_lo;
  logic [10:0]        t2_min_full;
  tod_t               tod_nxt;
  tod_t               tod_pipe_r [TOD_DEPTH];

  // busy only guards the reset window; the pipeline never backs up.
  assign busy      = !rst_n;
  assign in_accept = start && !busy;

  // Valid bits travel alongside the data; everything else needs no reset.
  assign vld_nxt = {vld_r[NUM_STAGES-2:0], in_accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1 works straight from the input ports. The numerator for b is
  // 4*JD - 7468865, taken modulo 2^25; it is positive and below 2^25 for
  // every Gregorian day, and its value does not matter for Julian days.
  always_comb begin
    s1_a_nxt     = {in_item.mjd_day[22], in_item.mjd_day} + mjdcal_pkg::JD_OFFSET;
    s1_greg_nxt  = $signed(in_item.mjd_day) >= mjdcal_pkg::GREG_MJD;
    s1_nb_nxt    = {in_item.mjd_day, 2'b00} + mjdcal_pkg::B_NUM_BIAS;
    t1_hprod_nxt = HP_W'(in_item.day_fraction) * HP_W'(mjdcal_pkg::HOURS_PER_DAY);
    t1_mprod_nxt = MP_W'(in_item.day_fraction) * MP_W'(mjdcal_pkg::MIN_PER_DAY);
    t1_uprod_nxt = UP_W'(in_item.day_fraction) * UP_W'(mjdcal_pkg::US_DAY_ODD);
  end

  // Stage 2: b estimate as n * floor(2^25 / 146097) / 2^25. For n below 2^25
  // it is the true quotient or one less.
  assign s2_pb_nxt = 33'(s1_nb_r) * 33'(mjdcal_pkg::B_RECIP);

  // Stage 3: one remainder check fixes the estimate.
  always_comb begin
    s3_qb    = s2_pb_r[mjdcal_pkg::B_SHIFT+7:mjdcal_pkg::B_SHIFT];
    s3_rb    = s2_nb_r - 25'(s3_qb) * 25'(mjdcal_pkg::B_DIV);
    s3_b_nxt = s3_qb + 8'(s3_rb >= 25'(mjdcal_pkg::B_DIV));
  end

  // Stage 4: Gregorian days get the century correction b - b/4.
  always_comb begin
    if (s3_greg_r) begin
      s4_c_nxt = s3_a_r + 24'(s3_b_r) - 24'(s3_b_r >> 2) + 24'(mjdcal_pkg::C_GREG_OFS);
    end else begin
      s4_c_nxt = s3_a_r + 24'(mjdcal_pkg::C_JUL_OFS);
    end
  end

  // Stage 5: 100*c - 12210, lifted by 5000 years' worth of 36525 so that the
  // numerator is never negative and stays below 2^30 over the whole input range.
  assign s5_nd_nxt = {{6{s4_c_r[23]}}, s4_c_r} * 30'd100 + mjdcal_pkg::D_NUM_OFS;

  // Stage 6: d estimate by reciprocal multiply, same scheme as for b.
  assign s6_pd_nxt = 45'(s5_nd_r) * 45'(mjdcal_pkg::D_RECIP);

  // Stage 7: correct the estimate and remove the bias.
  always_comb begin
    s7_qd     = s6_pd_r[mjdcal_pkg::D_SHIFT+14:mjdcal_pkg::D_SHIFT];
    s7_rd     = s6_nd_r - 30'(s7_qd) * 30'(mjdcal_pkg::D_DIV);
    s7_qd_fix = s7_qd + 15'(s7_rd >= 30'(mjdcal_pkg::D_DIV));
    s7_d_nxt  = 16'(s7_qd_fix) - 16'(mjdcal_pkg::D_BIAS);
  end

  // Stage 8: g = c - (365*d + floor(d/4)) always lies in 123..488, so only the
  // low nine bits of c and of the year start are needed.
  always_comb begin
    s8_e_lo  = s7_d_r[8:0] * mjdcal_pkg::YEAR_DAYS + s7_d_r[10:2];
    s8_g_nxt = s7_clo_r - s8_e_lo;
  end

  // Stage 9: f = floor(g / 30.6001) by comparing g with the month starts.
  always_comb begin
    for (int k = 0; k < mjdcal_pkg::NUM_F_THRESH; k++) begin
      s9_ge[k] = s8_g_r >= mjdcal_pkg::month_threshold(k + 1);
    end
    s9_f_nxt = 5'($countones(s9_ge));
  end

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      ofs_tab[k] = mjdcal_pkg::month_offset(k);
    end
  end

  // Stage 10: month from the shifted month, year from d, day from g.
  always_comb begin
    s10_f6 = {1'b0, s9_f_r};
    if (s9_f_r >= mjdcal_pkg::F_YEAR_WRAP) begin
      s10_mon6 = s10_f6 - mjdcal_pkg::F_WRAP_SUB;
    end else begin
      s10_mon6 = s10_f6 - 6'd1;
    end
    // January and February belong to the following year.
    s10_adj  = !s10_mon6[5] && (s10_mon6 >= mjdcal_pkg::MONTH_MARCH);
    s10_day9 = s9_g_r - ofs_tab[s9_f_r];

    out_nxt.cal_year     = s9_d_r[13:0] - mjdcal_pkg::YEAR_OFS - 14'(s10_adj);
    out_nxt.cal_month    = s10_mon6[3:0];
    out_nxt.cal_day      = s10_day9[4:0];
    out_nxt.cal_hour     = tod_pipe_r[TOD_DEPTH-1].hour;
    out_nxt.cal_minute   = tod_pipe_r[TOD_DEPTH-1].minute;
    out_nxt.second_micro = tod_pipe_r[TOD_DEPTH-1].micro;
  end

  // Time of day: hours and total minutes are the integer parts of the scaled
  // products; the microsecond count only needs its low 26 bits because the
  // difference to 60000000 times the minute count is below one minute.
  always_comb begin
    t2_hours       = t1_hprod_r[FB+4:FB];
    t2_mtot        = t1_mprod_r[FB+10:FB];
    t2_ut_lo       = t1_uprod_r[FB+12:FB-mjdcal_pkg::US_DAY_SHIFT];
    t2_min_full    = t2_mtot - 11'(t2_hours) * mjdcal_pkg::MIN_PER_HOUR;
    tod_nxt.hour   = t2_hours;
    tod_nxt.minute = t2_min_full[5:0];
    tod_nxt.micro  = t2_ut_lo - 26'(t2_mtot) * mjdcal_pkg::US_PER_MIN;
  end

  always_ff @(posedge clk) begin
    s1_a_r     <= s1_a_nxt;
    s1_greg_r  <= s1_greg_nxt;
    s1_nb_r    <= s1_nb_nxt;
    t1_hprod_r <= t1_hprod_nxt;
    t1_mprod_r <= t1_mprod_nxt;
    t1_uprod_r <= t1_uprod_nxt;

    s2_pb_r    <= s2_pb_nxt;
    s2_a_r     <= s1_a_r;
    s2_greg_r  <= s1_greg_r;
    s2_nb_r    <= s1_nb_r;

    s3_b_r     <= s3_b_nxt;
    s3_a_r     <= s2_a_r;
    s3_greg_r  <= s2_greg_r;

    s4_c_r     <= s4_c_nxt;

    s5_nd_r    <= s5_nd_nxt;
    s5_clo_r   <= s4_c_r[8:0];

    s6_pd_r    <= s6_pd_nxt;
    s6_nd_r    <= s5_nd_r;
    s6_clo_r   <= s5_clo_r;

    s7_d_r     <= s7_d_nxt;
    s7_clo_r   <= s6_clo_r;

    s8_g_r     <= s8_g_nxt;
    s8_d_r     <= s7_d_r;

    s9_f_r     <= s9_f_nxt;
    s9_g_r     <= s8_g_r;
    s9_d_r     <= s8_d_r;

    out_r      <= out_nxt;

    tod_pipe_r[0] <= tod_nxt;
    for (int k = 1; k < TOD_DEPTH; k++) begin
      tod_pipe_r[k] <= tod_pipe_r[k-1];
    end
  end

  assign out_valid  = vld_r[NUM_STAGES-1];
  assign out_result = out_r;

  `MJDCAL_ASSERT_AFTER(a_fixed_latency, in_accept, NUM_STAGES, out_valid)
  `MJDCAL_ASSERT_IMPLY(a_day_in_year, vld_r[7], s8_g_r >= mjdcal_pkg::G_MIN && s8_g_r <= mjdcal_pkg::G_MAX)
  `MJDCAL_ASSERT_IMPLY(a_month_range, out_valid, out_result.cal_month >= 4'd1 && out_result.cal_month <= 4'd12)
  `MJDCAL_ASSERT_IMPLY(a_day_range, out_valid, out_result.cal_day >= 5'd1)
  `MJDCAL_ASSERT_IMPLY(a_clock_range, out_valid, out_result.cal_hour <= 5'd23 && out_result.cal_minute <= 6'd59 && out_result.second_micro <= mjdcal_pkg::US_PER_MIN_MAX)

endmodule
